/* design/abpfs_pkg.sv */
// Shared types, constants and command codes for the block pair filter and sorter.
package abpfs_pkg;

  // Store capacity and block id range
  localparam int MaxPairs  = 64;
  localparam int MaxBlocks = 256;

  localparam int BlockIdW = 8;
  localparam int WeightW  = 32;
  localparam int GainW    = 32;
  localparam int RoundW   = 16;
  localparam int KeyW     = GainW + WeightW;
  localparam int IdxW     = (MaxPairs > 1) ? $clog2(MaxPairs) : 1;
  localparam int CntW     = $clog2(MaxPairs + 1);
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSkipSmall    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSmallLimit   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSkipZeroGain = 2'd2;

  // Input item
  typedef struct packed {
    logic [BlockIdW-1:0]    block_low;
    logic [BlockIdW-1:0]    block_high;
    logic                   edge_present;
    logic                   low_active;
    logic                   high_active;
    logic [WeightW-1:0]     cut_wt;
    logic signed [GainW-1:0] gain_sum;
    logic [RoundW-1:0]      round_number;
    logic                   last_pair;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [BlockIdW-1:0]    out_block_low;
    logic [BlockIdW-1:0]    out_block_high;
    logic [WeightW-1:0]     out_cut_wt;
    logic signed [GainW-1:0] out_gain_sum;
    logic                   last_result;
    logic                   list_empty;
    logic                   overflow;
  } out_item_t;

  // One entry of the sorted store
  typedef struct packed {
    logic [BlockIdW-1:0] block_low;
    logic [BlockIdW-1:0] block_high;
    logic [WeightW-1:0]  cut_wt;
    logic [GainW-1:0]    gain_sum;
  } entry_t;

  // Store write selection
  typedef enum logic [1:0] {
    WR_NONE     = 2'd0,
    WR_NEW_NEXT = 2'd1,
    WR_OLD_NEXT = 2'd2,
    WR_NEW_HEAD = 2'd3
  } wr_sel_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic    capture;
    logic    ins_begin;
    logic    ins_down;
    wr_sel_e wr_sel;
    logic    count_inc;
    logic    set_ovf;
    logic    emit_begin;
    logic    emit_next;
    logic    out_load_entry;
    logic    out_load_empty;
    logic    list_clear;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic keep;
    logic last;
    logic full;
    logic count_zero;
    logic key_ge;
    logic idx_zero;
    logic out_last;
  } status_t;

  // Sort key: gain with sign flipped above cut weight, compared unsigned
  function automatic logic [KeyW-1:0] make_key(logic [GainW-1:0] gain,
                                               logic [WeightW-1:0] cut);
    logic [GainW-1:0] flip;
    flip = {1'b1, {(GainW-1){1'b0}}};
    return {gain ^ flip, cut};
  endfunction

endpackage

/* design/abpfs_dp.sv */
// Datapath: config registers, filter, sorted store memory and result register.
module abpfs_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [abpfs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [abpfs_pkg::CfgDataW-1:0] cfg_data_i,
  input  abpfs_pkg::in_item_t       in_item_i,
  input  abpfs_pkg::cmd_t           cmd_i,
  output abpfs_pkg::status_t        status_o,
  output abpfs_pkg::out_item_t      out_item_o
);
  import abpfs_pkg::*;

  logic               skip_small_q;
  logic [WeightW-1:0] small_limit_q;
  logic               skip_zero_q;

  entry_t             new_q;
  logic               keep_q, keep_d;
  logic               last_q;
  logic [CntW-1:0]    count_q;
  logic               ovf_q;
  logic [IdxW-1:0]    idx_q, idx_d;
  entry_t             store_q [MaxPairs];
  entry_t             rd_data_q;
  out_item_t          out_q;

  logic               wr_en;
  logic [IdxW-1:0]    wr_addr;
  entry_t             wr_data;
  logic [IdxW-1:0]    idx_next;
  logic [IdxW-1:0]    count_top;
  logic               idx_last;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_small_q  <= 1'b0;
      small_limit_q <= '0;
      skip_zero_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSkipSmall:    skip_small_q  <= cfg_data_i[0];
        CfgSmallLimit:   small_limit_q <= cfg_data_i[WeightW-1:0];
        CfgSkipZeroGain: skip_zero_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Decide whether the incoming pair is kept
  always_comb begin
    keep_d = 1'b1;
    if ({1'b0, in_item_i.block_low} >= (BlockIdW+1)'(MaxBlocks) ||
        {1'b0, in_item_i.block_high} >= (BlockIdW+1)'(MaxBlocks)) begin
      keep_d = 1'b0;
    end
    if (!in_item_i.edge_present || !(in_item_i.low_active || in_item_i.high_active)) begin
      keep_d = 1'b0;
    end
    if (skip_small_q && (in_item_i.cut_wt < small_limit_q)) begin
      keep_d = 1'b0;
    end
    if (skip_zero_q && (in_item_i.round_number > RoundW'(1)) &&
        (in_item_i.gain_sum == '0)) begin
      keep_d = 1'b0;
    end
  end

  // Hold the captured item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      new_q.block_low  <= in_item_i.block_low;
      new_q.block_high <= in_item_i.block_high;
      new_q.cut_wt     <= in_item_i.cut_wt;
      new_q.gain_sum   <= in_item_i.gain_sum;
    end
  end

  // Control state: flags, fill count, overflow, walk index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q  <= 1'b0;
      last_q  <= 1'b0;
      count_q <= '0;
      ovf_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.capture) begin
        keep_q <= keep_d;
        last_q <= in_item_i.last_pair;
      end
      if (cmd_i.list_clear) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        if (cmd_i.count_inc) count_q <= count_q + CntW'(1);
        if (cmd_i.set_ovf)   ovf_q   <= 1'b1;
      end
    end
  end

  // Select the next walk index, which is also the read address
  assign count_top = IdxW'(count_q - CntW'(1));
  assign idx_next  = idx_q + IdxW'(1);

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.ins_begin)  idx_d = count_top;
    if (cmd_i.ins_down)   idx_d = idx_q - IdxW'(1);
    if (cmd_i.emit_begin) idx_d = '0;
    if (cmd_i.emit_next)  idx_d = idx_next;
  end

  // Select store write
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx_next;
    wr_data = new_q;
    case (cmd_i.wr_sel)
      WR_NEW_NEXT: begin
        wr_addr = idx_next;
        wr_data = new_q;
      end
      WR_OLD_NEXT: begin
        wr_addr = idx_next;
        wr_data = rd_data_q;
      end
      WR_NEW_HEAD: begin
        wr_addr = '0;
        wr_data = new_q;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Sorted store memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) store_q[wr_addr] <= wr_data;
    rd_data_q <= store_q[idx_d];
  end

  assign idx_last = (idx_q == count_top);

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_empty) begin
      out_q.out_block_low  <= '0;
      out_q.out_block_high <= '0;
      out_q.out_cut_wt     <= '0;
      out_q.out_gain_sum   <= '0;
      out_q.last_result    <= 1'b1;
      out_q.list_empty     <= 1'b1;
      out_q.overflow       <= ovf_q;
    end else if (cmd_i.out_load_entry) begin
      out_q.out_block_low  <= rd_data_q.block_low;
      out_q.out_block_high <= rd_data_q.block_high;
      out_q.out_cut_wt     <= rd_data_q.cut_wt;
      out_q.out_gain_sum   <= rd_data_q.gain_sum;
      out_q.last_result    <= idx_last;
      out_q.list_empty     <= 1'b0;
      out_q.overflow       <= ovf_q;
    end
  end

  assign out_item_o = out_q;

  // Report status
  assign status_o.keep       = keep_q;
  assign status_o.last       = last_q;
  assign status_o.full       = (count_q == CntW'(MaxPairs));
  assign status_o.count_zero = (count_q == '0);
  assign status_o.key_ge     = make_key(rd_data_q.gain_sum, rd_data_q.cut_wt) >=
                               make_key(new_q.gain_sum, new_q.cut_wt);
  assign status_o.idx_zero   = (idx_q == '0);
  assign status_o.out_last   = out_q.last_result;

endmodule

/* design/abpfs_ctrl.sv */
// Controller: sequences capture, sorted insertion and list emission.
module abpfs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  abpfs_pkg::status_t   status_i,
  output abpfs_pkg::cmd_t      cmd_o
);
  import abpfs_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DECIDE = 7'b0000010,
    ST_INS    = 7'b0000100,
    ST_HEAD   = 7'b0001000,
    ST_FINISH = 7'b0010000,
    ST_ELOAD  = 7'b0100000,
    ST_OWAIT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OWAIT);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.wr_sel = WR_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_FINISH;
        if (status_i.keep) begin
          if (status_i.full) begin
            cmd_o.set_ovf = 1'b1;
          end else if (status_i.count_zero) begin
            cmd_o.wr_sel    = WR_NEW_HEAD;
            cmd_o.count_inc = 1'b1;
          end else begin
            cmd_o.ins_begin = 1'b1;
            state_d = ST_INS;
          end
        end
      end
      ST_INS: begin
        // Place the new pair behind an entry that ranks equal or higher
        if (status_i.key_ge) begin
          cmd_o.wr_sel    = WR_NEW_NEXT;
          cmd_o.count_inc = 1'b1;
          state_d = ST_FINISH;
        end else begin
          cmd_o.wr_sel = WR_OLD_NEXT;
          if (status_i.idx_zero) begin
            state_d = ST_HEAD;
          end else begin
            cmd_o.ins_down = 1'b1;
          end
        end
      end
      ST_HEAD: begin
        cmd_o.wr_sel    = WR_NEW_HEAD;
        cmd_o.count_inc = 1'b1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status_i.last) begin
          state_d = ST_IDLE;
        end else if (status_i.count_zero) begin
          cmd_o.out_load_empty = 1'b1;
          state_d = ST_OWAIT;
        end else begin
          cmd_o.emit_begin = 1'b1;
          state_d = ST_ELOAD;
        end
      end
      ST_ELOAD: begin
        cmd_o.out_load_entry = 1'b1;
        state_d = ST_OWAIT;
      end
      ST_OWAIT: begin
        if (!out_stall_i) begin
          if (status_i.out_last) begin
            cmd_o.list_clear = 1'b1;
            state_d = ST_IDLE;
          end else begin
            cmd_o.emit_next = 1'b1;
            state_d = ST_ELOAD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* design/active_block_pair_filter_sort_top.sv */
// Sequence: an item is captured while idle; if it is dropped or meets a full or empty store it
// goes straight to the finish step, else the store is walked down from its top entry (one memory
// port each way), moving lower-ranked entries up until its place is found. No new item is taken
// until it is done; after the last item, results go out one at a time, each held on stall.
// Reset: asynchronous, active low; clears config, fill count and overflow flag. The store
// memory is not cleared; only entries below the fill count are ever read.
module active_block_pair_filter_sort_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [abpfs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [abpfs_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  abpfs_pkg::in_item_t            in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output abpfs_pkg::out_item_t           out_item_o
);
  import abpfs_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence the work
  abpfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Filter, store and emit
  abpfs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

endmodule
